>>> rtl/core/pegr_pkg.sv
// ----------------------------------------------------------------------------
// pegr_pkg
// Shared types, constants and register indexes of the envelope gain ramp.
// ----------------------------------------------------------------------------
package pegr_pkg;

  localparam int IDX_W   = 24;
  localparam int VOL_W   = 34;
  localparam int STEP_W  = 35;
  localparam int TBL_N   = 7;
  localparam int TIDX_W  = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NOTE_SAMPLES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_A      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_E      = 3'd6;

  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic start;      // accept a word, capture sample
    logic latch_tbl;  // note start: load table, zero ramp
    logic find;       // begin segment search
    logic step;       // apply volume step
    logic mul;        // multiply and launch result
  } pegr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic first;      // sample index is zero
    logic need_seg;   // sample index past segment end
    logic seg_done;   // segment search and divide finished
  } pegr_stat_t;

endpackage

>>> rtl/core/pegr_if.sv
// ----------------------------------------------------------------------------
// pegr_if
// Valid/ready channel interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
interface pegr_in_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_in;
  modport source (output valid, output pcm_in, input ready);
  modport sink   (input valid, input pcm_in, output ready);
endinterface

interface pegr_out_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_out;
  logic               note_end;
  modport source (output valid, output pcm_out, output note_end, input ready);
  modport sink   (input valid, input pcm_out, input note_end, output ready);
endinterface

interface pegr_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/pegr_div.sv
// ----------------------------------------------------------------------------
// pegr_div
// Restoring divider, one quotient bit per cycle, signed dividend,
// unsigned divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pegr_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [pegr_pkg::STEP_W-1:0] dividend,
  input  logic [pegr_pkg::IDX_W-1:0]   divisor,
  output logic                         busy,
  output logic signed [pegr_pkg::STEP_W-1:0] quotient
);
  import pegr_pkg::*;

  localparam int CNT_W = $clog2(STEP_W + 1);

  logic [STEP_W-1:0] quo;
  logic [IDX_W:0]    rem;
  logic [IDX_W-1:0]  dvs;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W:0]    trial;
  logic [IDX_W:0]    shifted;

  always_comb begin
    shifted = {rem[IDX_W-1:0], quo[STEP_W-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEP_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[STEP_W-1];
      quo <= dividend[STEP_W-1] ? STEP_W'(-dividend) : STEP_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[IDX_W]) begin
        rem <= trial;
        quo <= {quo[STEP_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[STEP_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

>>> rtl/core/pegr_dp.sv
// ----------------------------------------------------------------------------
// pegr_dp
// Datapath: registers, breakpoint table, segment search, volume ramp and
// sample multiply with output register.
// ----------------------------------------------------------------------------
module pegr_dp (
  input  logic                clk,
  input  logic                rst,
  input  pegr_pkg::pegr_cmd_t cmd,
  output pegr_pkg::pegr_stat_t stat,
  pegr_in_if.sink             in_ch,
  pegr_out_if.source          out_ch,
  pegr_cfg_if.sink            cfg_ch
);
  import pegr_pkg::*;

  // configuration registers
  logic [IDX_W-1:0] note_samples;
  logic [2:0]       point_count;
  logic [31:0]      point_reg [5];

  assign cfg_ch.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      note_samples <= IDX_W'(1);
      point_count  <= 3'd4;
      for (int k = 0; k < 5; k++) point_reg[k] <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_NOTE_SAMPLES) note_samples <= cfg_ch.data[IDX_W-1:0];
      else if (cfg_ch.index == REG_POINT_COUNT) point_count <= cfg_ch.data[2:0];
      else if (cfg_ch.index >= REG_POINT_A && cfg_ch.index <= REG_POINT_E)
        point_reg[3'(cfg_ch.index - REG_POINT_A)] <= cfg_ch.data;
    end
  end

  logic [IDX_W-1:0] note_len;
  logic [IDX_W-1:0] last;
  logic [2:0]       cnt_used;
  assign note_len = (note_samples == '0) ? IDX_W'(1) : note_samples;
  assign last     = note_len - 1'b1;
  assign cnt_used = (point_count < 3'd4) ? 3'd4 : ((point_count > 3'd5) ? 3'd5 : point_count);

  // table latch: front prefix sums clamped to last, back sums from last
  logic [IDX_W-1:0] bp_pos  [TBL_N];
  logic [7:0]       bp_gain [TBL_N];
  logic [TIDX_W-1:0] tbl_len;
  logic [IDX_W-1:0] tpos [TBL_N];
  logic [7:0]       tgain[TBL_N];

  always_comb begin
    logic [IDX_W+2:0] fp;
    logic signed [IDX_W+3:0] bp;
    logic [2:0] front;
    front = cnt_used - 3'd2;
    fp = '0;
    bp = $signed({4'b0, last});
    for (int k = 0; k < TBL_N; k++) begin
      tpos[k]  = '0;
      tgain[k] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      if (3'(k) < front) begin
        fp = fp + (IDX_W+3)'(point_reg[k][23:0]);
        tpos[k+1]  = (fp > (IDX_W+3)'(last)) ? last : fp[IDX_W-1:0];
        tgain[k+1] = point_reg[k][31:24];
      end
    end
    for (int k = 4; k >= 2; k--) begin
      if (3'(k) < cnt_used && 3'(k) >= front) begin
        bp = bp - $signed((IDX_W+4)'(point_reg[k][23:0]));
        tpos[k+1]  = (bp < 0) ? '0 : bp[IDX_W-1:0];
        tgain[k+1] = point_reg[k][31:24];
      end
    end
    tpos[cnt_used + 3'd1]  = last;
    tgain[cnt_used + 3'd1] = 8'd0;
  end

  // state
  logic [IDX_W-1:0]  sample_index;
  logic [TIDX_W-1:0] seg_target;
  logic [IDX_W-1:0]  seg_end;
  logic [VOL_W-1:0]  vol_acc;
  logic signed [STEP_W-1:0] vol_step;
  logic signed [15:0] sample;

  assign in_ch.ready = cmd.start;
  assign stat.first    = (sample_index == '0);
  assign stat.need_seg = (sample_index > seg_end);

  // segment search: one table entry per cycle, then divide
  localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_GQ = 2'd2, S_DIV = 2'd3;
  logic [1:0]        sstate;
  logic [TIDX_W-1:0] sj;
  logic [7:0]        prev_gain;
  logic              div_start, div_busy;
  logic signed [STEP_W-1:0] div_q, diff;
  logic [VOL_W-1:0]  gq_prev, gq_tgt;
  logic              diff_ok;
  logic signed [VOL_W+1:0] vol_sum;
  logic [VOL_W-1:0]  vol_next;

  // gain percent to Q2.32: floor((g*2^32+50)/100).
  // 2^32 = 100*42949672 + 96, so the quotient is g*42949672 plus
  // floor((96g+50)/100); that small remainder term is divided by a
  // reciprocal multiply (*5243 >> 19), exact for operands below 24531
  function automatic logic [VOL_W-1:0] gain_q(input logic [7:0] g);
    logic [14:0] rest;
    logic [28:0] prod;
    logic [9:0]  frac;
    rest = 15'(g) * 15'd96 + 15'd50;
    prod = 29'(rest) * 29'd5243;
    frac = prod[28:19];
    return VOL_W'(g) * VOL_W'(42949672) + VOL_W'(frac);
  endfunction

  assign stat.seg_done = (sstate == S_IDLE) && !div_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      sstate     <= S_IDLE;
      div_start  <= 1'b0;
      diff_ok    <= 1'b0;
      seg_target <= '0;
      seg_end    <= '0;
      vol_acc    <= '0;
      vol_step   <= '0;
    end else begin
      div_start <= 1'b0;
      case (sstate)
        S_IDLE: if (cmd.find) begin
          sj        <= seg_target + 1'b1;
          prev_gain <= bp_gain[seg_target];
          sstate    <= S_SCAN;
        end
        S_SCAN: begin
          if (sj >= tbl_len) begin
            seg_target <= tbl_len - 1'b1;
            seg_end    <= {IDX_W{1'b1}};
            vol_acc    <= '0;
            vol_step   <= '0;
            sstate     <= S_IDLE;
          end else if (bp_pos[sj] <= seg_end) begin
            prev_gain <= bp_gain[sj];
            sj        <= sj + 1'b1;
          end else begin
            sstate <= S_GQ;
          end
        end
        S_GQ: begin
          gq_prev   <= gain_q(prev_gain);
          gq_tgt    <= gain_q(bp_gain[sj]);
          sstate    <= S_DIV;
          div_start <= 1'b0;
        end
        S_DIV: begin
          if (!div_busy && !div_start && diff_ok == 1'b0) begin
            diff_ok   <= 1'b1;
            div_start <= 1'b1;
          end else if (diff_ok && !div_busy && !div_start) begin
            diff_ok    <= 1'b0;
            vol_acc    <= gq_prev;
            vol_step   <= div_q;
            seg_target <= sj;
            seg_end    <= bp_pos[sj];
            sstate     <= S_IDLE;
          end
        end
        default: sstate <= S_IDLE;
      endcase
      if (cmd.latch_tbl) begin
        seg_target <= '0;
        seg_end    <= '0;
        vol_acc    <= '0;
        vol_step   <= '0;
      end
      if (cmd.step) vol_acc <= vol_next;
    end
  end

  always_comb begin
    vol_sum = $signed({2'b0, vol_acc}) + (VOL_W+2)'(vol_step);
    if (vol_sum < 0) vol_next = '0;
    else if (vol_sum > $signed({2'b0, VOL_MAX})) vol_next = VOL_MAX;
    else vol_next = vol_sum[VOL_W-1:0];
  end

  assign diff = STEP_W'($signed({1'b0, gq_tgt}) - $signed({1'b0, gq_prev}));

  pegr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (bp_pos[sj] - seg_end),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_tbl) begin
      for (int k = 0; k < TBL_N; k++) begin
        bp_pos[k]  <= tpos[k];
        bp_gain[k] <= tgain[k];
      end
      tbl_len <= cnt_used + 3'd2;
    end
  end

  // sample capture, index advance
  always_ff @(posedge clk) begin
    if (rst) sample_index <= '0;
    else if (cmd.mul) begin
      if (sample_index + 1'b1 >= note_len) sample_index <= '0;
      else sample_index <= sample_index + 1'b1;
    end
  end
  always_ff @(posedge clk) if (in_ch.valid && cmd.start) sample <= in_ch.pcm_in;

  // multiply: 16 x 34 magnitude product
  logic [15:0] mag_in;
  logic [49:0] prod;
  logic [17:0] mag;
  logic signed [15:0] res;
  assign mag_in = sample[15] ? 16'(-sample) : 16'(sample);
  assign prod   = 50'(mag_in) * 50'(vol_acc);
  assign mag    = prod[49:32];
  always_comb begin
    if (sample[15]) res = (mag > 18'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, mag}));
    else            res = (mag > 18'd32767) ? 16'sd32767 : 16'(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (cmd.mul) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      out_ch.pcm_out  <= res;
      out_ch.note_end <= (sample_index + 1'b1 >= note_len);
    end
  end

endmodule

>>> rtl/core/pegr_ctrl.sv
// ----------------------------------------------------------------------------
// pegr_ctrl
// Controller: sequences accept, table latch, segment search, step, multiply.
// ----------------------------------------------------------------------------
module pegr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_busy,
  input  pegr_pkg::pegr_stat_t stat,
  output pegr_pkg::pegr_cmd_t  cmd
);
  import pegr_pkg::*;

  localparam logic [2:0] C_IDLE = 3'd0, C_DECIDE = 3'd1, C_WAIT = 3'd2,
                         C_STEP = 3'd3, C_MUL = 3'd4;
  logic [2:0] state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      C_IDLE: if (!out_busy && !rst) begin
        cmd.start = 1'b1;
        if (in_valid) state_next = C_DECIDE;
      end
      C_DECIDE: begin
        if (stat.first) begin
          cmd.latch_tbl = 1'b1;
          state_next = C_STEP;
        end else if (stat.need_seg) begin
          cmd.find = 1'b1;
          state_next = C_WAIT;
        end else state_next = C_STEP;
      end
      C_WAIT: if (stat.seg_done) state_next = C_STEP;
      C_STEP: begin
        cmd.step = 1'b1;
        state_next = C_MUL;
      end
      C_MUL: begin
        cmd.mul = 1'b1;
        state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= C_IDLE;
    else state <= state_next;
  end

endmodule

>>> rtl/core/pcm_envelope_gain_ramp.sv
// ----------------------------------------------------------------------------
// pcm_envelope_gain_ramp
// Piecewise-linear volume envelope applied to a note of 16-bit PCM samples.
// ----------------------------------------------------------------------------
// A word inside the current envelope segment passes from accept through the
// decide, step and multiply states, and its result is registered at the
// output. On the first word past a segment end the breakpoint search walks
// the table one entry per cycle and the step is computed by a bit-serial
// divider before the step and multiply states. One word is in flight at a
// time; a new word is taken only once the previous result has left the
// output register.
module pcm_envelope_gain_ramp (
  input  logic       clk,
  input  logic       rst,
  pegr_in_if.sink    in_ch,
  pegr_out_if.source out_ch,
  pegr_cfg_if.sink   cfg
);
  import pegr_pkg::*;

  pegr_cmd_t  cmd;
  pegr_stat_t stat;

  pegr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .out_busy (out_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  pegr_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg)
  );

endmodule
